>>> src/rtd_pkg.sv
// Shared types, codes and constants of the RTD resistance-to-temperature core.
// Used by the divider, the datapath, the controller and the top level.
`default_nettype none
package rtd_pkg;

    // Newton step limit
    localparam int MAX_ITER = 20;
    localparam int ITER_W   = $clog2(MAX_ITER + 1);

    // Field and register widths
    localparam int RES_W   = 24;
    localparam int A_W     = 36;
    localparam int B_W     = 40;
    localparam int C_W     = 47;
    localparam int LEAD_W  = 16;
    localparam int T_W     = 21;
    localparam int ST_W    = 2;
    localparam int CFG_W   = 47;
    localparam int CIDX_W  = 3;

    // Shared multiplier and divider widths
    localparam int MA_W    = 48;
    localparam int MB_W    = 25;
    localparam int MP_W    = MA_W + MB_W;
    localparam int NUM_W   = 62;
    localparam int DEN_W   = 44;
    localparam int DIV_STEPS = NUM_W / 2;
    localparam int DCNT_W  = $clog2(DIV_STEPS);

    // Temperature range, Q10 degrees
    localparam logic signed [T_W-1:0] T_MIN = -21'sd1048576;
    localparam logic signed [T_W-1:0] T_MAX = 21'sd1048575;

    // Register reset values
    localparam logic [RES_W-1:0]      R0_RST   = 24'd102400;
    localparam logic signed [A_W-1:0] A_RST    = 36'sd4297221295;
    localparam logic signed [B_W-1:0] B_RST    = -40'sd41613260557;
    localparam logic signed [C_W-1:0] C_RST    = -47'sd5056936703400;
    localparam logic [1:0]            MODE_RST = 2'd2;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_NOMINAL = 3'd0;
    localparam logic [CIDX_W-1:0] REG_LINEAR  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_SQUARE  = 3'd2;
    localparam logic [CIDX_W-1:0] REG_QUARTIC = 3'd3;
    localparam logic [CIDX_W-1:0] REG_WIRING  = 3'd4;
    localparam logic [CIDX_W-1:0] REG_LEAD    = 3'd5;

    localparam logic [1:0] MODE_TWO_WIRE = 2'd0;

    // Result status codes
    localparam logic [ST_W-1:0] STS_CONV  = 2'd0;
    localparam logic [ST_W-1:0] STS_LIMIT = 2'd1;
    localparam logic [ST_W-1:0] STS_FLAT  = 2'd2;
    localparam logic [ST_W-1:0] STS_SAT   = 2'd3;

    // Datapath operations
    localparam int OP_W = 5;
    localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
    localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
    localparam logic [OP_W-1:0] OP_DIV1  = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV2  = 5'd3;
    localparam logic [OP_W-1:0] OP_INIT  = 5'd4;
    localparam logic [OP_W-1:0] OP_M_AT  = 5'd5;
    localparam logic [OP_W-1:0] OP_M_BT  = 5'd6;
    localparam logic [OP_W-1:0] OP_M_BTT = 5'd7;
    localparam logic [OP_W-1:0] OP_M_CT  = 5'd8;
    localparam logic [OP_W-1:0] OP_M_X1  = 5'd9;
    localparam logic [OP_W-1:0] OP_M_X2  = 5'd10;
    localparam logic [OP_W-1:0] OP_M_X3  = 5'd11;
    localparam logic [OP_W-1:0] OP_M_GC  = 5'd12;
    localparam logic [OP_W-1:0] OP_A_GC  = 5'd13;
    localparam logic [OP_W-1:0] OP_M_QH  = 5'd14;
    localparam logic [OP_W-1:0] OP_M_QL  = 5'd15;
    localparam logic [OP_W-1:0] OP_A_E   = 5'd16;
    localparam logic [OP_W-1:0] OP_M_DEN = 5'd17;
    localparam logic [OP_W-1:0] OP_A_DEN = 5'd18;
    localparam logic [OP_W-1:0] OP_DIV3  = 5'd19;
    localparam logic [OP_W-1:0] OP_UPD   = 5'd20;
    localparam logic [OP_W-1:0] OP_OUT   = 5'd21;

    // Controller to datapath
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ST_W-1:0] status;
        logic            zero_t;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic bad_cfg;
        logic t_neg;
        logic conv;
        logic den_zero;
        logic sat;
        logic div_done;
    } t_dp_stat;

endpackage
`default_nettype wire

>>> src/rtd_resistance_to_temperature_core.sv
// RTD resistance to temperature (Callendar-Van Dusen Newton inversion).
// The first guess takes two divides; then each Newton step at or above zero
// runs a multiply sequence plus a divide, with a longer multiply sequence
// below zero. One beat in flight; the input stalls until the result is handed
// off. Synchronous active-low reset returns the control and configuration
// registers to their defaults.
`default_nettype none
module rtd_resistance_to_temperature_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output logic                                    o_in_stall,
    input  wire logic [rtd_pkg::RES_W-1:0]          i_measured_resistance,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_stall,
    output logic signed [rtd_pkg::T_W-1:0]          o_temperature,
    output logic [rtd_pkg::ST_W-1:0]                o_status,
    input  wire logic                               i_cfg_we,
    input  wire logic [rtd_pkg::CIDX_W-1:0]         i_cfg_index,
    input  wire logic [rtd_pkg::CFG_W-1:0]          i_cfg_wdata
);
    import rtd_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    rtd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    rtd_dp u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_wdata           (i_cfg_wdata),
        .i_measured_resistance (i_measured_resistance),
        .i_cmd                 (cmd),
        .o_stat                (stat),
        .o_temperature         (o_temperature),
        .o_status              (o_status)
    );

endmodule
`default_nettype wire

>>> src/rtd_div.sv
// Unsigned restoring divider, two quotient bits per cycle.
// Depends on rtd_pkg for the operand widths.
`default_nettype none
module rtd_div (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_start,
    input  wire logic [rtd_pkg::NUM_W-1:0] i_num,
    input  wire logic [rtd_pkg::DEN_W-1:0] i_den,
    output logic                           o_done,
    output logic [rtd_pkg::NUM_W-1:0]      o_quot
);
    import rtd_pkg::*;

    logic [DEN_W-1:0]  r_rem, n_rem;
    logic [NUM_W-1:0]  r_quo, n_quo;
    logic [DEN_W-1:0]  r_den;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    s1, s2;
    logic              ge1, ge2;
    logic [DEN_W-1:0]  rem1;
    logic [NUM_W-1:0]  quo1;

    // two restoring steps
    always_comb begin
        s1   = {r_rem, r_quo[NUM_W-1]};
        ge1  = (s1 >= {1'b0, r_den});
        rem1 = ge1 ? DEN_W'(s1 - {1'b0, r_den}) : s1[DEN_W-1:0];
        quo1 = {r_quo[NUM_W-2:0], ge1};
        s2   = {rem1, quo1[NUM_W-1]};
        ge2  = (s2 >= {1'b0, r_den});
        n_rem = ge2 ? DEN_W'(s2 - {1'b0, r_den}) : s2[DEN_W-1:0];
        n_quo = {quo1[NUM_W-2:0], ge2};
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule
`default_nettype wire

>>> src/rtd_dp.sv
// Datapath: configuration registers, shared multiplier, Newton state and result.
// Depends on rtd_pkg and rtd_div.
`default_nettype none
module rtd_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [rtd_pkg::CIDX_W-1:0]        i_cfg_index,
    input  wire logic [rtd_pkg::CFG_W-1:0]         i_cfg_wdata,
    input  wire logic [rtd_pkg::RES_W-1:0]         i_measured_resistance,
    input  wire rtd_pkg::t_dp_cmd                  i_cmd,
    output rtd_pkg::t_dp_stat                      o_stat,
    output logic signed [rtd_pkg::T_W-1:0]         o_temperature,
    output logic [rtd_pkg::ST_W-1:0]               o_status
);
    import rtd_pkg::*;

    // configuration
    logic [RES_W-1:0]      r_r0;
    logic signed [A_W-1:0] r_a;
    logic signed [B_W-1:0] r_b;
    logic signed [C_W-1:0] r_c;
    logic [1:0]            r_mode;
    logic [LEAD_W-1:0]     r_lead;

    // working state
    logic signed [25:0]     r_r;
    logic signed [T_W-1:0]  r_t;
    logic                   r_sat;
    logic signed [MP_W-1:0] r_prod;
    logic signed [40:0]     r_p;
    logic signed [40:0]     r_g;
    logic signed [41:0]     r_x2;
    logic signed [51:0]     r_hi;
    logic signed [52:0]     r_e;
    logic signed [45:0]     r_den;
    logic                   r_qsgn;
    logic signed [T_W-1:0]  r_out_t;
    logic [ST_W-1:0]        r_out_st;

    logic signed [MA_W-1:0] m_a;
    logic signed [MB_W-1:0] m_b;
    logic signed [MB_W-1:0] t_ext, t_m, t_g, r0_ext;
    logic signed [41:0]     q;
    logic signed [25:0]     diff;
    logic [24:0]            diff_mag;
    logic [A_W-1:0]         a_mag;
    logic [40:0]            q1_mag;
    logic [39:0]            e_mag;
    logic [DEN_W-1:0]       den_mag;
    logic signed [63:0]     qv, nt;
    logic [T_W:0]           clamped;
    logic                   div_start, div_done;
    logic [NUM_W-1:0]       div_num, div_quot;
    logic [DEN_W-1:0]       div_den;

    // clamp to the temperature range, sat flag on top
    function automatic logic [T_W:0] clamp_t(input logic signed [63:0] v);
        logic [T_W:0] res;
        if (v < 64'(T_MIN))      res = {1'b1, T_MIN};
        else if (v > 64'(T_MAX)) res = {1'b1, T_MAX};
        else                     res = {1'b0, v[T_W-1:0]};
        return res;
    endfunction

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r0   <= R0_RST;
            r_a    <= A_RST;
            r_b    <= B_RST;
            r_c    <= C_RST;
            r_mode <= MODE_RST;
            r_lead <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_NOMINAL: r_r0   <= i_cfg_wdata[RES_W-1:0];
                REG_LINEAR:  r_a    <= $signed(i_cfg_wdata[A_W-1:0]);
                REG_SQUARE:  r_b    <= $signed(i_cfg_wdata[B_W-1:0]);
                REG_QUARTIC: r_c    <= $signed(i_cfg_wdata[C_W-1:0]);
                REG_WIRING:  r_mode <= i_cfg_wdata[1:0];
                REG_LEAD:    r_lead <= i_cfg_wdata[LEAD_W-1:0];
                default: ;
            endcase
        end
    end

    // derived operands
    always_comb begin
        t_ext  = MB_W'(r_t);
        t_m    = t_ext - 25'sd102400;
        t_g    = (t_ext <<< 2) - 25'sd307200;
        r0_ext = $signed({1'b0, r_r0});
        q      = 42'sd4294967296 + 42'(r_p);
        diff   = r_r - $signed({2'b0, r_r0});
        diff_mag = diff[25] ? 25'(-diff) : diff[24:0];
        a_mag  = r_a[A_W-1] ? A_W'(~r_a + 1'b1) : r_a;
        q1_mag = (div_quot > NUM_W'(64'd1099511627776)) ? 41'd1099511627776
                                                         : div_quot[40:0];
        if (r_e > 53'sd549755813888)        e_mag = 40'd549755813888;
        else if (r_e < -53'sd549755813888)  e_mag = 40'd549755813888;
        else if (r_e[52])                   e_mag = 40'(-r_e);
        else                                e_mag = r_e[39:0];
        den_mag = r_den[45] ? DEN_W'(-r_den) : r_den[DEN_W-1:0];
        qv = r_qsgn ? -$signed({2'b0, div_quot}) : $signed({2'b0, div_quot});
        nt = (i_cmd.op == OP_UPD) ? 64'(r_t) - qv : qv;
        clamped = clamp_t(nt);
    end

    // multiplier operand select
    always_comb begin
        m_a = '0;
        m_b = '0;
        unique case (i_cmd.op)
            OP_M_AT:  begin m_a = MA_W'(r_a);               m_b = t_ext;  end
            OP_M_BT:  begin m_a = MA_W'(r_b);               m_b = t_ext;  end
            OP_M_BTT: begin m_a = MA_W'(r_prod >>> 30);     m_b = t_ext;  end
            OP_M_CT:  begin m_a = MA_W'(r_c >>> 6);         m_b = t_ext;  end
            OP_M_X1:  begin m_a = MA_W'(r_prod >>> 20);     m_b = t_ext;  end
            OP_M_X2:  begin m_a = MA_W'(r_prod >>> 20);     m_b = t_ext;  end
            OP_M_X3:  begin m_a = MA_W'(r_prod >>> 20);     m_b = t_m;    end
            OP_M_GC:  begin m_a = MA_W'(r_x2);              m_b = t_g;    end
            OP_M_QH:  begin m_a = MA_W'($signed(q[41:16])); m_b = r0_ext; end
            OP_M_QL:  begin m_a = MA_W'($signed({1'b0, q[15:0]})); m_b = r0_ext; end
            OP_M_DEN: begin m_a = MA_W'(r_g >>> 8);         m_b = r0_ext; end
            default: ;
        endcase
    end

    // divider operand select
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (i_cmd.op)
            OP_DIV1: begin
                div_start = 1'b1;
                div_num   = NUM_W'({diff_mag, 32'b0});
                div_den   = DEN_W'(r_r0);
            end
            OP_DIV2: begin
                div_start = 1'b1;
                div_num   = NUM_W'({q1_mag, 18'b0});
                div_den   = DEN_W'(a_mag);
            end
            OP_DIV3: begin
                div_start = (r_den != '0);
                div_num   = {e_mag, 22'b0};
                div_den   = den_mag;
            end
            default: ;
        endcase
    end

    rtd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // product register
    always_ff @(posedge i_clk) begin
        r_prod <= m_a * m_b;
    end

    // sequenced updates
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD:  r_r <= $signed(26'({2'b0, i_measured_resistance})
                             - ((r_mode == MODE_TWO_WIRE) ? 26'({r_lead, 1'b0}) : 26'd0));
            OP_DIV1:  r_qsgn <= diff[25];
            OP_DIV2:  r_qsgn <= r_qsgn ^ r_a[A_W-1];
            OP_DIV3:  r_qsgn <= r_e[52] ^ r_den[45];
            OP_INIT, OP_UPD: begin
                r_t   <= $signed(clamped[T_W-1:0]);
                r_sat <= clamped[T_W];
            end
            OP_M_BT:  r_p  <= 41'(r_prod >>> 18);
            OP_M_BTT: r_g  <= 41'(r_a) + 41'(r_prod >>> 25);
            OP_M_CT:  r_p  <= r_p + 41'(r_prod >>> 14);
            OP_M_X2:  r_x2 <= 42'(r_prod >>> 20);
            OP_M_GC:  r_p  <= r_p + 41'(r_prod >>> 22);
            OP_A_GC:  r_g  <= r_g + 41'(r_prod >>> 24);
            OP_M_QL:  r_hi <= 52'(r_prod);
            OP_A_E:   r_e  <= ((53'(r_hi) + 53'($signed({1'b0, r_prod[39:16]}))) >>> 8)
                              - (53'(r_r) <<< 8);
            OP_A_DEN: r_den <= 46'(r_prod >>> 12);
            OP_OUT: begin
                r_out_t  <= i_cmd.zero_t ? '0 : r_t;
                r_out_st <= i_cmd.status;
            end
            default: ;
        endcase
    end

    // status back to the controller
    always_comb begin
        o_stat.bad_cfg  = (r_r0 == '0) || (r_a == '0);
        o_stat.t_neg    = r_t[T_W-1];
        o_stat.conv     = (r_e > -53'sd256) && (r_e < 53'sd256);
        o_stat.den_zero = (r_den == '0);
        o_stat.sat      = r_sat;
        o_stat.div_done = div_done;
    end

    assign o_temperature = r_out_t;
    assign o_status      = r_out_st;

endmodule
`default_nettype wire

>>> src/rtd_ctrl.sv
// Controller: sequences the initial guess, Newton steps and result handoff.
// Depends on rtd_pkg; drives rtd_dp through t_dp_cmd.
`default_nettype none
module rtd_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    input  wire rtd_pkg::t_dp_stat  i_stat,
    output rtd_pkg::t_dp_cmd        o_cmd
);
    import rtd_pkg::*;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_DIV1  = 5'd1;
    localparam logic [4:0] ST_WAIT1 = 5'd2;
    localparam logic [4:0] ST_DIV2  = 5'd3;
    localparam logic [4:0] ST_WAIT2 = 5'd4;
    localparam logic [4:0] ST_INIT  = 5'd5;
    localparam logic [4:0] ST_AT    = 5'd6;
    localparam logic [4:0] ST_BT    = 5'd7;
    localparam logic [4:0] ST_BTT   = 5'd8;
    localparam logic [4:0] ST_CT    = 5'd9;
    localparam logic [4:0] ST_X1    = 5'd10;
    localparam logic [4:0] ST_X2    = 5'd11;
    localparam logic [4:0] ST_X3    = 5'd12;
    localparam logic [4:0] ST_GC    = 5'd13;
    localparam logic [4:0] ST_AGC   = 5'd14;
    localparam logic [4:0] ST_QH    = 5'd15;
    localparam logic [4:0] ST_QL    = 5'd16;
    localparam logic [4:0] ST_AE    = 5'd17;
    localparam logic [4:0] ST_MDEN  = 5'd18;
    localparam logic [4:0] ST_ADEN  = 5'd19;
    localparam logic [4:0] ST_DIV3  = 5'd20;
    localparam logic [4:0] ST_WAIT3 = 5'd21;
    localparam logic [4:0] ST_UPD   = 5'd22;
    localparam logic [4:0] ST_DONE  = 5'd23;

    logic [4:0]        r_state, n_state;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [ST_W-1:0]   r_status, n_status;
    logic              r_zero, n_zero;
    logic              r_out_valid, n_out_valid;
    logic [OP_W-1:0]   op;

    // next state and command
    always_comb begin
        n_state  = r_state;
        n_iter   = r_iter;
        n_status = r_status;
        n_zero   = r_zero;
        op       = OP_NOP;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) begin
                op      = OP_LOAD;
                n_iter  = '0;
                n_zero  = 1'b0;
                n_state = ST_DIV1;
            end
            ST_DIV1: begin
                if (i_stat.bad_cfg) begin
                    n_zero  = 1'b1;
                    n_state = ST_DONE;
                end else begin
                    op      = OP_DIV1;
                    n_state = ST_WAIT1;
                end
            end
            ST_WAIT1: if (i_stat.div_done) n_state = ST_DIV2;
            ST_DIV2: begin
                op      = OP_DIV2;
                n_state = ST_WAIT2;
            end
            ST_WAIT2: if (i_stat.div_done) n_state = ST_INIT;
            ST_INIT: begin
                op      = OP_INIT;
                n_state = ST_AT;
            end
            // polynomial and slope at the current estimate
            ST_AT:  begin op = OP_M_AT;  n_state = ST_BT;  end
            ST_BT:  begin op = OP_M_BT;  n_state = ST_BTT; end
            ST_BTT: begin op = OP_M_BTT; n_state = ST_CT;  end
            ST_CT: begin
                op      = OP_M_CT;
                n_state = i_stat.t_neg ? ST_X1 : ST_QH;
            end
            ST_X1:  begin op = OP_M_X1;  n_state = ST_X2;  end
            ST_X2:  begin op = OP_M_X2;  n_state = ST_X3;  end
            ST_X3:  begin op = OP_M_X3;  n_state = ST_GC;  end
            ST_GC:  begin op = OP_M_GC;  n_state = ST_AGC; end
            ST_AGC: begin op = OP_A_GC;  n_state = ST_QH;  end
            // residual
            ST_QH:  begin op = OP_M_QH;  n_state = ST_QL;  end
            ST_QL:  begin op = OP_M_QL;  n_state = ST_AE;  end
            ST_AE:  begin op = OP_A_E;   n_state = ST_MDEN; end
            ST_MDEN: begin
                op = OP_M_DEN;
                if (i_stat.conv) begin
                    n_status = STS_CONV;
                    n_state  = ST_DONE;
                end else begin
                    n_state  = ST_ADEN;
                end
            end
            ST_ADEN: begin op = OP_A_DEN; n_state = ST_DIV3; end
            ST_DIV3: begin
                op = OP_DIV3;
                if (i_stat.den_zero) begin
                    n_status = STS_FLAT;
                    n_state  = ST_DONE;
                end else begin
                    n_state  = ST_WAIT3;
                end
            end
            ST_WAIT3: if (i_stat.div_done) n_state = ST_UPD;
            ST_UPD: begin
                op = OP_UPD;
                if (r_iter == ITER_W'(MAX_ITER - 1)) begin
                    n_status = STS_LIMIT;
                    n_state  = ST_DONE;
                end else begin
                    n_iter  = r_iter + 1'b1;
                    n_state = ST_AT;
                end
            end
            // hand result to the output register once it is free
            ST_DONE: if (!r_out_valid || !i_out_stall) begin
                op      = OP_OUT;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign n_out_valid = (op == OP_OUT) || (r_out_valid && i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_status    <= STS_CONV;
            r_zero      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_iter      <= n_iter;
            r_status    <= n_status;
            r_zero      <= n_zero;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        o_cmd.op     = op;
        o_cmd.zero_t = r_zero;
        o_cmd.status = (r_zero || i_stat.sat) ? STS_SAT : r_status;
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

    // checks
    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_iter < ITER_W'(MAX_ITER))
        else $error("Newton step count past limit");

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a waiting beat");

    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_DIV1))
        else $error("accepted beat did not start a solve");

    a_upd_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |=> (r_state == ST_AT || r_state == ST_DONE))
        else $error("bad sequence after update");

endmodule
`default_nettype wire
